@@ rtl/kspa_pkg.sv @@
// Shared types and codes for the keyed slot pool allocator.
// No dependencies; imported by every module of the block but kspa_slot_ram.
`default_nettype none

package kspa_pkg;

    localparam int POOL_DEPTH_DEFAULT = 64;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_FREE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0]  free_count;
        logic [SLOT_W-1:0]   result_index;
        logic [STATUS_W-1:0] status;
    } kspa_res_t;

endpackage

`default_nettype wire

@@ rtl/keyed_slot_pool_allocator.sv @@
// Keyed slot pool allocator: LIFO free list of POOL_DEPTH slots with key lookup.
// Path from accept to m_tvalid: allocate and free go through ST_ALLOC or ST_FREE, then
// ST_DONE, then the output register; an item refused at once (empty pool, slot out of range,
// unused func) goes straight to ST_DONE; find scans in ST_FIND until a hit or the last slot,
// one slot compared per cycle through a single read port of the slot store.
// One item at a time: the next is taken the cycle after the result moves into the output
// register. After rst_n, a clearing pass chains the slots; s_tready stays low meanwhile.
`default_nettype none

module keyed_slot_pool_allocator
    import kspa_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // func[1:0], slot_index[7:2], session_key[39:8], file_key[71:40]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], result_index[7:2], free_count[14:8], zero[15]
    output logic      [15:0] m_tdata
);

    localparam int IW     = $clog2(POOL_DEPTH);
    localparam int LW     = $clog2(POOL_DEPTH + 1);
    localparam int WORD_W = 1 + LW + 2 * KEY_W;

    // unpack the input item
    logic [FUNC_W-1:0] in_func;
    logic [SLOT_W-1:0] in_slot;
    logic [KEY_W-1:0]  in_skey;
    logic [KEY_W-1:0]  in_fkey;

    assign in_func = s_tdata[1:0];
    assign in_slot = s_tdata[7:2];
    assign in_skey = s_tdata[39:8];
    assign in_fkey = s_tdata[71:40];

    // sequencer <-> slot store
    logic              ram_wr_en;
    logic [IW-1:0]     ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic [IW-1:0]     ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    // finished result and output register
    logic      res_valid;
    logic      res_take;
    kspa_res_t res;
    logic      m_valid_reg, m_valid_next;
    kspa_res_t m_res_reg, m_res_next;

    kspa_ctrl #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (in_func),
        .in_slot     (in_slot),
        .in_skey     (in_skey),
        .in_fkey     (in_fkey),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    kspa_slot_ram #(
        .DEPTH  (POOL_DEPTH),
        .WORD_W (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Move the result into the output register when it is empty or being
    // drained this cycle; otherwise hold it in the sequencer.
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_take)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg};

endmodule

`default_nettype wire

@@ rtl/kspa_key_match.sv @@
// Slot compare unit: flags a used slot whose session and file keys equal the query.
// Depends on kspa_pkg for the key width.
`default_nettype none

module kspa_key_match
    import kspa_pkg::*;
(
    input  wire logic             used,
    input  wire logic [KEY_W-1:0] slot_skey,
    input  wire logic [KEY_W-1:0] slot_fkey,
    input  wire logic [KEY_W-1:0] query_skey,
    input  wire logic [KEY_W-1:0] query_fkey,
    output logic                  hit
);

    assign hit = used && (slot_skey == query_skey) && (slot_fkey == query_fkey);

endmodule

`default_nettype wire

@@ rtl/kspa_slot_ram.sv @@
// Slot store: one write port, one read port with registered read data.
// Each word holds the used flag, the next link and both keys of a slot.
`default_nettype none

module kspa_slot_ram #(
    parameter int DEPTH  = 64,
    parameter int WORD_W = 75
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WORD_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WORD_W-1:0]        rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/kspa_ctrl.sv @@
// Sequencer of the allocator: clearing pass, alloc/free list updates and key scan.
// Depends on kspa_pkg and kspa_key_match; drives the ports of kspa_slot_ram.
`default_nettype none

module kspa_ctrl
    import kspa_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT,
    localparam int IW        = $clog2(POOL_DEPTH),
    localparam int LW        = $clog2(POOL_DEPTH + 1),
    localparam int WORD_W    = 1 + LW + 2 * KEY_W
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [FUNC_W-1:0]   in_func,
    input  wire logic [SLOT_W-1:0]   in_slot,
    input  wire logic [KEY_W-1:0]    in_skey,
    input  wire logic [KEY_W-1:0]    in_fkey,
    output logic                     res_valid,
    input  wire logic                res_take,
    output kspa_res_t                res,
    output logic                     ram_wr_en,
    output logic      [IW-1:0]       ram_wr_addr,
    output logic      [WORD_W-1:0]   ram_wr_data,
    output logic      [IW-1:0]       ram_rd_addr,
    input  wire logic [WORD_W-1:0]   ram_rd_data
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ALLOC = 3'd2;
    localparam logic [2:0] ST_FREE  = 3'd3;
    localparam logic [2:0] ST_FIND  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [LW-1:0] END_MARK  = LW'(POOL_DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(POOL_DEPTH - 1);
    localparam logic [31:0]   DEPTH_32  = 32'(POOL_DEPTH);

    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       cnt_reg, cnt_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       free_reg, free_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic [KEY_W-1:0]    skey_reg, skey_next;
    logic [KEY_W-1:0]    fkey_reg, fkey_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;

    // fields of the word read back from the slot store
    logic                rd_used;
    logic [LW-1:0]       rd_link;
    logic [KEY_W-1:0]    rd_skey;
    logic [KEY_W-1:0]    rd_fkey;
    logic                hit;

    assign {rd_used, rd_link, rd_skey, rd_fkey} = ram_rd_data;

    kspa_key_match u_match (
        .used       (rd_used),
        .slot_skey  (rd_skey),
        .slot_fkey  (rd_fkey),
        .query_skey (skey_reg),
        .query_fkey (fkey_reg),
        .hit        (hit)
    );

    assign res_valid = (state_reg == ST_DONE);
    assign res       = '{free_count:   COUNT_W'(free_reg),
                         result_index: idx_reg,
                         status:       status_reg};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        head_next   = head_reg;
        free_next   = free_reg;
        slot_next   = slot_reg;
        skey_next   = skey_reg;
        fkey_next   = fkey_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        in_ready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_reg;
        ram_wr_data = {1'b0, LW'(cnt_reg) + LW'(1), {(2 * KEY_W){1'b0}}};
        ram_rd_addr = cnt_reg + IW'(1);

        case (state_reg)
            ST_INIT:
            begin
                // chain slot i to i+1; the last one links to the end mark
                ram_wr_en = 1'b1;
                if (cnt_reg == LAST_SLOT)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                case (in_func)
                    FUNC_ALLOC: ram_rd_addr = IW'(head_reg);
                    FUNC_FREE:  ram_rd_addr = IW'(in_slot);
                    default:    ram_rd_addr = '0;
                endcase
                if (in_valid)
                begin
                    skey_next = in_skey;
                    fkey_next = in_fkey;
                    slot_next = IW'(in_slot);
                    idx_next  = '0;
                    case (in_func)
                        FUNC_ALLOC:
                        begin
                            if (head_reg == END_MARK)
                            begin
                                status_next = STAT_EXHAUSTED;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_ALLOC;
                            end
                        end
                        FUNC_FREE:
                        begin
                            if ({{(32 - SLOT_W){1'b0}}, in_slot} >= DEPTH_32)
                            begin
                                status_next = STAT_BAD_FREE;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_FREE;
                            end
                        end
                        FUNC_FIND:
                        begin
                            cnt_next   = '0;
                            state_next = ST_FIND;
                        end
                        default:
                        begin
                            status_next = STAT_NOT_FOUND;
                            state_next  = ST_DONE;
                        end
                    endcase
                end
            end

            ST_ALLOC:
            begin
                // pop the head slot and store the keys with it
                ram_wr_en   = 1'b1;
                ram_wr_addr = IW'(head_reg);
                ram_wr_data = {1'b1, rd_link, skey_reg, fkey_reg};
                head_next   = rd_link;
                free_next   = free_reg - LW'(1);
                status_next = STAT_OK;
                idx_next    = SLOT_W'(head_reg);
                state_next  = ST_DONE;
            end

            ST_FREE:
            begin
                if (!rd_used)
                begin
                    status_next = STAT_BAD_FREE;
                end
                else
                begin
                    // push the slot in front of the current head
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = slot_reg;
                    ram_wr_data = {1'b0, head_reg, rd_skey, rd_fkey};
                    head_next   = LW'(slot_reg);
                    free_next   = free_reg + LW'(1);
                    status_next = STAT_OK;
                    idx_next    = SLOT_W'(slot_reg);
                end
                state_next = ST_DONE;
            end

            ST_FIND:
            begin
                // data for slot cnt is here; the read for cnt+1 is under way
                if (hit)
                begin
                    status_next = STAT_OK;
                    idx_next    = SLOT_W'(cnt_reg);
                    state_next  = ST_DONE;
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            head_reg  <= '0;
            free_reg  <= END_MARK;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        skey_reg   <= skey_next;
        fkey_reg   <= fkey_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
    end

    a_empty_list_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == END_MARK) |-> (free_reg == '0))
        else $error("list head at end mark while free slots remain");

    a_free_left_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg == '0) |-> (head_reg == END_MARK))
        else $error("free count zero while list head names a slot");

    a_alloc_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC) |=> (free_reg == $past(free_reg) - LW'(1)))
        else $error("allocate did not take one slot off the free count");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in progress");

endmodule

`default_nettype wire

@@ tb/keyed_slot_pool_allocator_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for keyed_slot_pool_allocator: directed table then random
// allocate / free / find traffic, checked against an in-bench free-list predictor.
// Depends on kspa_pkg and the keyed_slot_pool_allocator RTL only.

module keyed_slot_pool_allocator_tb;
    import kspa_pkg::*;

    localparam int DEPTH        = POOL_DEPTH_DEFAULT;
    localparam int RAND_ITEMS   = 800;
    localparam int QUIET_ITEMS  = 120;
    localparam int CYCLE_LIMIT  = 500000;
    localparam logic [6:0] END_MARK = 7'(DEPTH);
    // func 3 is not an operation; the block answers it as not found
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  fkey;
        logic [KEY_W-1:0]  skey;
        logic [SLOT_W-1:0] slot;
        logic [FUNC_W-1:0] func;
    } pool_cmd_t;

    typedef struct {
        pool_cmd_t cmd;
        int        reps;
        bit        typed;
        kspa_res_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // predictor copy of the pool
    logic [6:0]        link_mem [DEPTH];
    bit                busy     [DEPTH];
    logic [6:0]        head_ptr;
    logic [COUNT_W-1:0] free_cnt;
    logic [KEY_W-1:0]  sess_mem [DEPTH];
    logic [KEY_W-1:0]  file_mem [DEPTH];

    kspa_res_t replies_due[$];
    dir_row_t  dir_rows[$];
    int        errors = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;

    keyed_slot_pool_allocator #(
        .POOL_DEPTH(DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Chain every slot in index order, slot 0 at the head, none in use.
    task automatic pool_clear();
        for (int i = 0; i < DEPTH; i++)
        begin
            link_mem[i] = 7'(i + 1);
            busy[i]     = 1'b0;
            sess_mem[i] = '0;
            file_mem[i] = '0;
        end
        head_ptr = 7'd0;
        free_cnt = COUNT_W'(DEPTH);
    endtask

    // Apply one item to the predicted pool and return the reply it causes.
    function automatic kspa_res_t pool_update(pool_cmd_t c);
        kspa_res_t  r;
        logic [6:0] h;
        bit         hit;
        r.status       = STAT_NOT_FOUND;
        r.result_index = '0;
        hit            = 1'b0;
        case (c.func)
            FUNC_ALLOC:
            begin
                if (head_ptr >= END_MARK)
                    r.status = STAT_EXHAUSTED;
                else
                begin
                    h = head_ptr;
                    head_ptr = link_mem[h];
                    busy[h] = 1'b1;
                    sess_mem[h] = c.skey;
                    file_mem[h] = c.fkey;
                    free_cnt = free_cnt - 1'b1;
                    r.status = STAT_OK;
                    r.result_index = h[SLOT_W-1:0];
                end
            end
            FUNC_FREE:
            begin
                if (!busy[c.slot])
                    r.status = STAT_BAD_FREE;
                else
                begin
                    link_mem[c.slot] = head_ptr;
                    head_ptr = {1'b0, c.slot};
                    busy[c.slot] = 1'b0;
                    free_cnt = free_cnt + 1'b1;
                    r.status = STAT_OK;
                    r.result_index = c.slot;
                end
            end
            FUNC_FIND:
            begin
                // first used slot in index order whose two keys both match
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!hit && busy[i] && sess_mem[i] == c.skey && file_mem[i] == c.fkey)
                    begin
                        hit = 1'b1;
                        r.status = STAT_OK;
                        r.result_index = SLOT_W'(i);
                    end
                end
            end
            default: ;
        endcase
        r.free_count = free_cnt;
        return r;
    endfunction

    // Return a random slot that is in use, or -1 when the pool is empty of them.
    function automatic int pick_used();
        int n;
        int k;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (busy[i])
                n++;
        if (n == 0)
            return -1;
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (busy[i])
            begin
                if (k == 0)
                    return i;
                k--;
            end
        end
        return -1;
    endfunction

    // Favor a tiny key set and the all-ones corner so duplicates show up.
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom_range(0, 3));
            1: return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 1));
            default: return KEY_W'($urandom());
        endcase
    endfunction

    // Build one random item. mode 0 fills the pool, 1 drains it, 2 mixes.
    function automatic pool_cmd_t rand_cmd(int mode);
        pool_cmd_t c;
        int        roll;
        int        u;
        int        p_alloc;
        int        p_free;
        case (mode)
            0: begin p_alloc = 75; p_free = 85; end
            1: begin p_alloc = 10; p_free = 85; end
            default: begin p_alloc = 35; p_free = 65; end
        endcase
        roll   = $urandom_range(0, 99);
        u      = pick_used();
        c.slot = SLOT_W'($urandom_range(0, DEPTH - 1));
        c.skey = rand_key();
        c.fkey = rand_key();
        if (roll < p_alloc)
        begin
            c.func = FUNC_ALLOC;
            // reuse the keys of a live slot now and then
            if (u >= 0 && $urandom_range(0, 6) == 0)
            begin
                c.skey = sess_mem[u];
                c.fkey = file_mem[u];
            end
        end
        else if (roll < p_free)
        begin
            c.func = FUNC_FREE;
            if (u >= 0 && $urandom_range(0, 99) < 85)
                c.slot = SLOT_W'(u);
        end
        else if (roll < 97)
        begin
            c.func = FUNC_FIND;
            if (u >= 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        c.skey = sess_mem[u];
                        c.fkey = file_mem[u];
                    end
                    6: c.skey = sess_mem[u];
                    7: c.fkey = file_mem[u];
                    default: ;
                endcase
            end
        end
        else
            c.func = FUNC_UNUSED;
        return c;
    endfunction

    // Present one item, hold it until accepted, then log its reply.
    // A typed row supplies its own reply; the predictor still advances.
    task automatic send_item(pool_cmd_t c, bit typed, kspa_res_t want, bit may_idle);
        kspa_res_t pred;
        int        gap;
        gap = 0;
        if (may_idle && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.fkey, c.skey, c.slot, c.func};
        do @(posedge clk); while (!s_tready);
        pred = pool_update(c);
        replies_due.push_back(typed ? want : pred);
    endtask

    // Drop valid and wait for every outstanding reply.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (replies_due.size() != 0);
    endtask

    function automatic dir_row_t mk_row(logic [FUNC_W-1:0] f, int slot, logic [KEY_W-1:0] sk,
                                        logic [KEY_W-1:0] fk, int reps, bit typed,
                                        logic [STATUS_W-1:0] st, int idx, int cnt);
        dir_row_t r;
        r.cmd.func  = f;
        r.cmd.slot  = SLOT_W'(slot);
        r.cmd.skey  = sk;
        r.cmd.fkey  = fk;
        r.reps      = reps;
        r.typed     = typed;
        r.want.status       = st;
        r.want.result_index = SLOT_W'(idx);
        r.want.free_count   = COUNT_W'(cnt);
        return r;
    endfunction

    // Receiver: ready in random runs, with random stalls between them, none in the quiet tail.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge clk);
            if (!quiet && $urandom_range(0, 1) == 1)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    // Compare every accepted reply, field by field, with the oldest one due.
    always @(posedge clk)
    begin
        kspa_res_t got;
        kspa_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[14:0];
            if (replies_due.size() == 0)
            begin
                $display("%0t: reply with nothing outstanding: status %0d index %0d count %0d",
                         $time, got.status, got.result_index, got.free_count);
                errors++;
            end
            else
            begin
                exp_r = replies_due.pop_front();
                if (got.status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, got.status);
                    errors++;
                end
                if (got.result_index !== exp_r.result_index)
                begin
                    $display("%0t: result_index expected %0d actual %0d",
                             $time, exp_r.result_index, got.result_index);
                    errors++;
                end
                if (got.free_count !== exp_r.free_count)
                begin
                    $display("%0t: free_count expected %0d actual %0d",
                             $time, exp_r.free_count, got.free_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: give up well past the slowest legal run.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        pool_cmd_t c;
        int        mode;
        int        phase_end;
        bit        calm;

        pool_clear();

        // Directed table: typed rows are plain reads of the free-list rules.
        dir_rows.push_back(mk_row(FUNC_FIND, 0, 32'h0, 32'h0, 1, 1, STAT_NOT_FOUND, 0, 64));
        dir_rows.push_back(mk_row(FUNC_FREE, 0, 32'h0, 32'h0, 1, 1, STAT_BAD_FREE, 0, 64));
        dir_rows.push_back(mk_row(FUNC_UNUSED, 63, '1, '1, 1, 1, STAT_NOT_FOUND, 0, 64));
        dir_rows.push_back(mk_row(FUNC_ALLOC, 63, '1, '1, 1, 1, STAT_OK, 0, 63));
        dir_rows.push_back(mk_row(FUNC_ALLOC, 0, 32'h0, 32'h0, 1, 1, STAT_OK, 1, 62));
        dir_rows.push_back(mk_row(FUNC_ALLOC, 0, '1, 32'h0, 1, 1, STAT_OK, 2, 61));
        dir_rows.push_back(mk_row(FUNC_FIND, 0, '1, '1, 1, 1, STAT_OK, 0, 61));
        dir_rows.push_back(mk_row(FUNC_FIND, 0, 32'h0, 32'h0, 1, 1, STAT_OK, 1, 61));
        // one key matching is not a match
        dir_rows.push_back(mk_row(FUNC_FIND, 0, 32'h0, '1, 1, 1, STAT_NOT_FOUND, 0, 61));
        dir_rows.push_back(mk_row(FUNC_FIND, 0, '1, 32'h0, 1, 1, STAT_OK, 2, 61));
        dir_rows.push_back(mk_row(FUNC_FREE, 1, 32'h0, 32'h0, 1, 1, STAT_OK, 1, 62));
        // double free is rejected
        dir_rows.push_back(mk_row(FUNC_FREE, 1, 32'h0, 32'h0, 1, 1, STAT_BAD_FREE, 0, 62));
        dir_rows.push_back(mk_row(FUNC_FIND, 0, 32'h0, 32'h0, 1, 1, STAT_NOT_FOUND, 0, 62));
        // last freed slot comes back first
        dir_rows.push_back(mk_row(FUNC_ALLOC, 0, 32'h12345678, 32'h9abcdef0, 1, 1,
                                  STAT_OK, 1, 61));
        dir_rows.push_back(mk_row(FUNC_ALLOC, 0, '1, '1, 1, 1, STAT_OK, 3, 60));
        // duplicate keys: lowest index wins
        dir_rows.push_back(mk_row(FUNC_FIND, 0, '1, '1, 1, 1, STAT_OK, 0, 60));
        dir_rows.push_back(mk_row(FUNC_FREE, 0, 32'h0, 32'h0, 1, 1, STAT_OK, 0, 61));
        dir_rows.push_back(mk_row(FUNC_FIND, 0, '1, '1, 1, 1, STAT_OK, 3, 61));
        dir_rows.push_back(mk_row(FUNC_FREE, 63, 32'h0, 32'h0, 1, 1, STAT_BAD_FREE, 0, 61));
        // fill the pool; keys step with each repeat
        dir_rows.push_back(mk_row(FUNC_ALLOC, 5, 32'hA5A50000, 32'h5A5A0000, 61, 0,
                                  STAT_OK, 0, 0));
        dir_rows.push_back(mk_row(FUNC_ALLOC, 0, 32'h0, 32'h0, 1, 1, STAT_EXHAUSTED, 0, 0));
        dir_rows.push_back(mk_row(FUNC_FIND, 0, 32'h12345678, 32'h9abcdef0, 1, 1,
                                  STAT_OK, 1, 0));
        dir_rows.push_back(mk_row(FUNC_FREE, 63, 32'h0, 32'h0, 1, 1, STAT_OK, 63, 1));
        dir_rows.push_back(mk_row(FUNC_ALLOC, 0, 32'h0, 32'h0, 1, 1, STAT_OK, 63, 0));
        dir_rows.push_back(mk_row(FUNC_FREE, 42, 32'h0, 32'h0, 1, 1, STAT_OK, 42, 1));

        // hold reset low, once, then release it
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // s_tready stays low through the clearing pass, so the first send just waits
        foreach (dir_rows[i])
        begin
            for (int r = 0; r < dir_rows[i].reps; r++)
            begin
                c = dir_rows[i].cmd;
                c.skey = c.skey + KEY_W'(r);
                c.fkey = c.fkey + KEY_W'(r);
                send_item(c, dir_rows[i].typed, dir_rows[i].want, 1'b1);
            end
        end
        drain_replies();

        // Random traffic in phases of fill, drain and mixed work.
        mode      = 0;
        phase_end = 0;
        calm      = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == phase_end)
            begin
                mode      = $urandom_range(0, 2);
                phase_end = n + $urandom_range(30, 90);
                calm      = ($urandom_range(0, 3) == 0);
            end
            quiet = (n >= RAND_ITEMS - QUIET_ITEMS);
            if (n % 200 == 199)
                drain_replies();
            send_item(rand_cmd(mode), 1'b0, '0, !quiet && !calm);
        end
        s_tvalid <= 1'b0;

        // wait out the replies, then one full scan for anything stray
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
